// File: sv/mecanum_odometry_integrator_macros.svh
// Assertion helpers for the odometry integrator
`ifndef MECANUM_ODOMETRY_INTEGRATOR_MACROS_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_MACROS_SVH
`define MOI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MOI_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// File: sv/moi_pkg.sv
`default_nettype none
package moi_pkg;
  localparam int unsigned CordicStepsDef = 24;
  localparam int unsigned AtanLen = 32;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam logic [0:0] RegLinear = 1'b0;
  localparam logic [0:0] RegAngular = 1'b1;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StFront = 5'b00010,
    StIter  = 5'b00100,
    StMul   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic iter;
    logic mul;
    logic acc;
  } cmd_t;

  function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0: atan_turn = 32'sd536870912;
      5'd1: atan_turn = 32'sd316933406;
      5'd2: atan_turn = 32'sd167458907;
      5'd3: atan_turn = 32'sd85004756;
      5'd4: atan_turn = 32'sd42667331;
      5'd5: atan_turn = 32'sd21354465;
      5'd6: atan_turn = 32'sd10679838;
      5'd7: atan_turn = 32'sd5340245;
      5'd8: atan_turn = 32'sd2670163;
      5'd9: atan_turn = 32'sd1335087;
      5'd10: atan_turn = 32'sd667544;
      5'd11: atan_turn = 32'sd333772;
      5'd12: atan_turn = 32'sd166886;
      5'd13: atan_turn = 32'sd83443;
      5'd14: atan_turn = 32'sd41722;
      5'd15: atan_turn = 32'sd20861;
      5'd16: atan_turn = 32'sd10430;
      5'd17: atan_turn = 32'sd5215;
      5'd18: atan_turn = 32'sd2608;
      5'd19: atan_turn = 32'sd1304;
      5'd20: atan_turn = 32'sd652;
      5'd21: atan_turn = 32'sd326;
      5'd22: atan_turn = 32'sd163;
      5'd23: atan_turn = 32'sd81;
      5'd24: atan_turn = 32'sd41;
      5'd25: atan_turn = 32'sd20;
      5'd26: atan_turn = 32'sd10;
      5'd27: atan_turn = 32'sd5;
      5'd28: atan_turn = 32'sd3;
      5'd29: atan_turn = 32'sd1;
      5'd30: atan_turn = 32'sd1;
      default: atan_turn = 32'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: sv/moi_if.sv
`default_nettype none
interface moi_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] count_front_left;
  logic signed [15:0] count_front_right;
  logic signed [15:0] count_rear_left;
  logic signed [15:0] count_rear_right;
  modport source(output valid, count_front_left, count_front_right, count_rear_left,
                 count_rear_right, input ready);
  modport sink(input valid, count_front_left, count_front_right, count_rear_left,
               count_rear_right, output ready);
endinterface

interface moi_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] x_position;
  logic signed [63:0] y_position;
  logic [31:0] heading;
  modport source(output valid, x_position, y_position, heading, input ready);
  modport sink(input valid, x_position, y_position, heading, output ready);
endinterface
`default_nettype wire

// File: sv/moi_ctrl.sv
`default_nettype none
module moi_ctrl #(
  parameter int unsigned CordicSteps = moi_pkg::CordicStepsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output moi_pkg::cmd_t cmd_o,
  output logic [4:0] iter_o
);
  localparam int unsigned Steps = (CordicSteps > moi_pkg::AtanLen) ?
      moi_pkg::AtanLen : CordicSteps;
  localparam logic [4:0] LastIter = 5'(Steps - 1);
  localparam logic [4:0] LastChunk = 5'd2;

  moi_pkg::state_e state_q, state_d;
  logic [4:0] iter_q, iter_d;
  logic busy_valid_q, busy_valid_d;

  wire accept = in_valid_i && in_ready_o;
  wire out_free = !busy_valid_q || out_ready_i;

  assign in_ready_o = (state_q == moi_pkg::StIdle);
  assign out_valid_o = busy_valid_q;
  assign iter_o = iter_q;

  always_comb begin
    state_d = state_q;
    iter_d = iter_q;
    busy_valid_d = busy_valid_q && !out_ready_i;
    cmd_o = '0;
    case (state_q)
      moi_pkg::StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d = moi_pkg::StFront;
        end
      end
      moi_pkg::StFront: begin
        cmd_o.prep = 1'b1;
        iter_d = '0;
        state_d = moi_pkg::StIter;
      end
      moi_pkg::StIter: begin
        cmd_o.iter = 1'b1;
        if (iter_q == LastIter) begin
          iter_d = '0;
          state_d = moi_pkg::StMul;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      moi_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        iter_d = iter_q + 5'd1;
        if (iter_q == LastChunk) state_d = moi_pkg::StOut;
      end
      moi_pkg::StOut: begin
        if (out_free) begin
          cmd_o.acc = 1'b1;
          busy_valid_d = 1'b1;
          state_d = moi_pkg::StIdle;
        end
      end
      default: state_d = moi_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= moi_pkg::StIdle;
      iter_q <= '0;
      busy_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q <= iter_d;
      busy_valid_q <= busy_valid_d;
    end
  end
endmodule
`default_nettype wire

// File: sv/moi_dp.sv
`default_nettype none
module moi_dp (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  moi_pkg::cmd_t cmd_i,
  input  wire logic [4:0] iter_i,
  input  wire logic [31:0] linear_scale_i,
  input  wire logic [31:0] angular_scale_i,
  input  wire logic signed [15:0] cnt0_i,
  input  wire logic signed [15:0] cnt1_i,
  input  wire logic signed [15:0] cnt2_i,
  input  wire logic signed [15:0] cnt3_i,
  output logic signed [63:0] x_o,
  output logic signed [63:0] y_o,
  output logic [31:0] heading_o
);
  logic [15:0] last_q [4];
  logic [31:0] head_q;
  logic [31:0] hout_q;
  logic signed [63:0] xacc_q, yacc_q;
  logic signed [17:0] slin_q, str_q, srot_q;
  logic signed [50:0] fwd_q, side_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic flip_q;
  logic signed [85:0] px_q, py_q;

  logic signed [15:0] d0, d1, d2, d3;
  assign d0 = 16'(cnt0_i - last_q[0]);
  assign d1 = 16'(cnt1_i - last_q[1]);
  assign d2 = 16'(cnt2_i - last_q[2]);
  assign d3 = 16'(cnt3_i - last_q[3]);

  logic signed [50:0] rot_prod;
  logic [31:0] head_new;
  assign rot_prod = 51'(srot_q) * $signed({19'd0, angular_scale_i});
  assign head_new = head_q + 32'(rot_prod >>> 16);

  logic [31:0] ang_adj;
  logic fl;
  assign fl = head_new[31] ^ head_new[30];
  assign ang_adj = fl ? head_new + 32'h8000_0000 : head_new;

  logic signed [33:0] xs, ys, at;
  assign xs = cx_q >>> iter_i;
  assign ys = cy_q >>> iter_i;
  assign at = 34'(moi_pkg::atan_turn(iter_i));

  logic signed [33:0] cs, sn;
  assign cs = flip_q ? -cx_q : cx_q;
  assign sn = flip_q ? -cy_q : cy_q;

  // dot products over three 17-bit slices of the step, exact, floor shift by 38
  logic signed [17:0] fch, sch;
  always_comb begin
    case (iter_i)
      5'd0: begin
        fch = $signed({1'b0, fwd_q[16:0]});
        sch = $signed({1'b0, side_q[16:0]});
      end
      5'd1: begin
        fch = $signed({1'b0, fwd_q[33:17]});
        sch = $signed({1'b0, side_q[33:17]});
      end
      default: begin
        fch = $signed({fwd_q[50], fwd_q[50:34]});
        sch = $signed({side_q[50], side_q[50:34]});
      end
    endcase
  end

  logic signed [51:0] p_fc, p_ss, p_fs, p_sc;
  assign p_fc = 52'(fch) * 52'(cs);
  assign p_ss = 52'(sch) * 52'(sn);
  assign p_fs = 52'(fch) * 52'(sn);
  assign p_sc = 52'(sch) * 52'(cs);

  logic signed [52:0] tx, ty;
  assign tx = 53'(p_fc) - 53'(p_ss);
  assign ty = 53'(p_fs) + 53'(p_sc);

  logic signed [85:0] txs, tys;
  always_comb begin
    case (iter_i)
      5'd0: begin
        txs = 86'(tx);
        tys = 86'(ty);
      end
      5'd1: begin
        txs = 86'(tx) <<< 17;
        tys = 86'(ty) <<< 17;
      end
      default: begin
        txs = 86'(tx) <<< 34;
        tys = 86'(ty) <<< 34;
      end
    endcase
  end

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) sat_add = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (s < -65'sh0_8000_0000_0000_0000) sat_add = 64'sh8000_0000_0000_0000;
    else sat_add = s[63:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) last_q[k] <= '0;
      head_q <= '0;
      hout_q <= '0;
      xacc_q <= '0;
      yacc_q <= '0;
    end else begin
      if (cmd_i.load) begin
        last_q[0] <= cnt0_i;
        last_q[1] <= cnt1_i;
        last_q[2] <= cnt2_i;
        last_q[3] <= cnt3_i;
      end
      if (cmd_i.prep) head_q <= head_new;
      if (cmd_i.acc) begin
        xacc_q <= sat_add(xacc_q, 64'(px_q >>> 38));
        yacc_q <= sat_add(yacc_q, 64'(py_q >>> 38));
        hout_q <= head_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slin_q <= 18'(d0) + 18'(d1) + 18'(d2) + 18'(d3);
      str_q <= 18'(d0) - 18'(d1) - 18'(d2) + 18'(d3);
      srot_q <= 18'(d0) - 18'(d1) + 18'(d2) - 18'(d3);
    end
    if (cmd_i.prep) begin
      fwd_q <= 51'(slin_q) * $signed({19'd0, linear_scale_i});
      side_q <= 51'(str_q) * $signed({19'd0, linear_scale_i});
      flip_q <= fl;
      cx_q <= moi_pkg::CordicGain;
      cy_q <= '0;
      cz_q <= 34'($signed(ang_adj));
    end
    if (cmd_i.iter) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.mul) begin
      px_q <= ((iter_i == 5'd0) ? 86'sd0 : px_q) + txs;
      py_q <= ((iter_i == 5'd0) ? 86'sd0 : py_q) + tys;
    end
  end

  assign x_o = xacc_q;
  assign y_o = yacc_q;
  assign heading_o = hout_q;
endmodule
`default_nettype wire

// File: sv/mecanum_odometry_integrator.sv
// Channel   Dir  Payload
// in_if     in   four 16-bit encoder counts
// out_if    out  x_position, y_position (64 bit), heading (32 bit)
// APB       in   linear_scale @0x0, angular_scale @0x4
// Each sample passes through accept, setup, the CORDIC iterations, three
// multiply passes and the final write.
// Reset clears counts, heading and position; output held until taken.
// A pending result stalls the next sample only at its final write.
`default_nettype none
module mecanum_odometry_integrator #(
  parameter int unsigned CORDIC_STEPS = moi_pkg::CordicStepsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  moi_in_if.sink    in_if,
  moi_out_if.source out_if,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [31:0] lin_q, ang_q;
  moi_pkg::cmd_t cmd;
  logic [4:0] iter;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= '0;
      ang_q <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == moi_pkg::RegLinear) lin_q <= pwdata;
      else ang_q <= pwdata;
    end
  end
  assign prdata = (paddr[2] == moi_pkg::RegLinear) ? lin_q : ang_q;

  moi_ctrl #(.CordicSteps(CORDIC_STEPS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .iter_o(iter)
  );

  moi_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .iter_i(iter),
    .linear_scale_i(lin_q), .angular_scale_i(ang_q),
    .cnt0_i(in_if.count_front_left), .cnt1_i(in_if.count_front_right),
    .cnt2_i(in_if.count_rear_left), .cnt3_i(in_if.count_rear_right),
    .x_o(out_if.x_position), .y_o(out_if.y_position), .heading_o(out_if.heading)
  );
endmodule
`default_nettype wire

// File: sv/moi_checker.sv
`default_nettype none
`include "mecanum_odometry_integrator_macros.svh"
module moi_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] heading
);
  `MOI_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready |=> !in_ready)
  `MOI_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid)
  `MOI_ASSERT(a_head_stable, clk_i, rst_ni, out_valid && !out_ready |=> $stable(heading))
  `MOI_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |-> !out_valid)
endmodule

bind mecanum_odometry_integrator moi_checker u_moi_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .heading(out_if.heading)
);
`default_nettype wire

// File: tb/sv/tb_mecanum_odometry_integrator.sv
`default_nettype none
module tb_mecanum_odometry_integrator;

  localparam int unsigned Steps = moi_pkg::CordicStepsDef;
  localparam int unsigned IdleLimit = 3000;

  localparam longint AtanTurn [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0
  };

  typedef struct {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [31:0] h;
  } pose_t;

  typedef struct {
    bit is_cfg;
    logic [0:0] reg_idx;
    logic [31:0] value;
    logic signed [15:0] cnt [4];
    bit has_pose;
    pose_t pose;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  moi_in_if in_bus ();
  moi_out_if out_bus ();

  mecanum_odometry_integrator #(.CORDIC_STEPS(Steps)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus.sink),
    .out_if (out_bus.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  logic [31:0] lin_scale;
  logic [31:0] ang_scale;
  logic [15:0] last_cnt [4];
  logic [31:0] head_acc;
  logic signed [63:0] x_acc;
  logic signed [63:0] y_acc;

  pose_t pose_q[$];
  int errors;
  int results_seen;
  int idle_cycles;
  int cycle_cnt;
  int hold_cnt;
  bit long_hold_done;
  logic signed [15:0] sent_cnt [4];

  always #4 clk_i = ~clk_i;

  function automatic longint floor_shr(longint v, int unsigned n);
    return v >>> n;
  endfunction

  function automatic void cordic_rot(input logic [31:0] angle, output longint c,
                                     output longint s);
    bit flip;
    logic [31:0] a;
    longint z;
    longint cx;
    longint cy;
    longint xs;
    longint ys;
    flip = ((angle + 32'h4000_0000) & 32'h8000_0000) != 0;
    a = flip ? angle + 32'h8000_0000 : angle;
    z = longint'($signed(a));
    cx = moi_pkg::CordicGain;
    cy = 0;
    for (int i = 0; i < Steps && i < 32; i++) begin
      xs = floor_shr(cx, i);
      ys = floor_shr(cy, i);
      if (z >= 0) begin
        cx -= ys; cy += xs; z -= AtanTurn[i];
      end else begin
        cx += ys; cy -= xs; z += AtanTurn[i];
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
  endfunction

  function automatic logic signed [63:0] dot_step(longint f, longint p, longint g,
                                                  longint q);
    logic signed [127:0] wf;
    logic signed [127:0] wg;
    logic signed [127:0] sum;
    wf = f;
    wg = g;
    sum = wf * p + wg * q;
    sum = sum >>> 38;
    return sum[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] acc,
                                                 logic signed [63:0] d);
    logic signed [64:0] sum;
    sum = {acc[63], acc} + {d[63], d};
    if (sum[64] != sum[63])
      return sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return sum[63:0];
  endfunction

  function automatic pose_t integrate_sample(logic signed [15:0] cnt [4]);
    longint d [4];
    logic [15:0] diff;
    longint s_lin;
    longint s_tr;
    longint s_rot;
    longint fwd;
    longint side;
    longint c;
    longint s;
    longint turn;
    pose_t p;
    for (int k = 0; k < 4; k++) begin
      diff = cnt[k] - last_cnt[k];
      d[k] = longint'($signed(diff));
      last_cnt[k] = cnt[k];
    end
    s_lin = d[0] + d[1] + d[2] + d[3];
    s_tr = d[0] - d[1] - d[2] + d[3];
    s_rot = d[0] - d[1] + d[2] - d[3];
    turn = (s_rot * longint'({32'd0, ang_scale})) >>> 16;
    head_acc = head_acc + turn[31:0];
    fwd = s_lin * longint'({32'd0, lin_scale});
    side = s_tr * longint'({32'd0, lin_scale});
    cordic_rot(head_acc, c, s);
    x_acc = sat_add(x_acc, dot_step(fwd, c, side, -s));
    y_acc = sat_add(y_acc, dot_step(fwd, s, side, c));
    p.x = x_acc;
    p.y = y_acc;
    p.h = head_acc;
    return p;
  endfunction

  task automatic wait_drained();
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (Steps + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == moi_pkg::RegLinear) lin_scale = value;
    else ang_scale = value;
  endtask

  task automatic send_sample(logic signed [15:0] cnt [4], int seq, bit has_pose,
                             pose_t typed);
    int gap;
    pose_t p;
    gap = 0;
    if (seq % 100 >= 20) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3: gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.count_front_left <= cnt[0];
    in_bus.count_front_right <= cnt[1];
    in_bus.count_rear_left <= cnt[2];
    in_bus.count_rear_right <= cnt[3];
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    p = integrate_sample(cnt);
    if (has_pose && (p.x != typed.x || p.y != typed.y || p.h != typed.h)) begin
      $error("typed pose disagrees with prediction");
      errors++;
    end
    pose_q.push_back(has_pose ? typed : p);
    sent_cnt = cnt;
  endtask

  function automatic row_t sample_row(int a, int b, int c, int d, bit has_pose);
    row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = moi_pkg::RegLinear;
    r.value = '0;
    r.cnt[0] = 16'(a); r.cnt[1] = 16'(b); r.cnt[2] = 16'(c); r.cnt[3] = 16'(d);
    r.has_pose = has_pose;
    r.pose.x = '0; r.pose.y = '0; r.pose.h = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [0:0] idx, logic [31:0] value);
    row_t r;
    r = sample_row(0, 0, 0, 0, 1'b0);
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1;
        if (pose_q.size() == 0) begin
          $error("result with no pose expected");
          errors++;
        end else begin
          if (out_bus.x_position !== pose_q[0].x) begin
            $error("x_position expected %0d got %0d", pose_q[0].x, out_bus.x_position);
            errors++;
          end
          if (out_bus.y_position !== pose_q[0].y) begin
            $error("y_position expected %0d got %0d", pose_q[0].y, out_bus.y_position);
            errors++;
          end
          if (out_bus.heading !== pose_q[0].h) begin
            $error("heading expected %0h got %0h", pose_q[0].h, out_bus.heading);
            errors++;
          end
          void'(pose_q.pop_front());
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_bus.ready <= 1'b0;
      end else if (results_seen >= 150 && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_cnt <= 300;
        out_bus.ready <= 1'b0;
      end else if (cycle_cnt % 256 < 48) begin
        out_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        hold_cnt <= $urandom_range(10, 40);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= $urandom_range(0, 9) > 2;
      end
    end
  end

  initial begin
    row_t rows[$];
    logic signed [15:0] cnt [4];
    logic [31:0] lin_set [6];
    logic [31:0] ang_set [6];
    pose_t none;
    int seq;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.count_front_left = '0;
    in_bus.count_front_right = '0;
    in_bus.count_rear_left = '0;
    in_bus.count_rear_right = '0;
    out_bus.ready = 1'b0;
    lin_scale = '0;
    ang_scale = '0;
    for (int k = 0; k < 4; k++) begin
      last_cnt[k] = '0;
      sent_cnt[k] = '0;
    end
    head_acc = '0;
    x_acc = '0;
    y_acc = '0;
    errors = 0;
    results_seen = 0;
    idle_cycles = 0;
    cycle_cnt = 0;
    hold_cnt = 0;
    long_hold_done = 1'b0;
    none.x = '0; none.y = '0; none.h = '0;
    seq = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back(sample_row(0, 0, 0, 0, 1'b1));
    rows.push_back(sample_row(32767, 32767, 32767, 32767, 1'b1));
    rows.push_back(sample_row(-32768, -32768, -32768, -32768, 1'b1));
    rows.push_back(sample_row(32767, -32768, 32767, -32768, 1'b1));
    rows.push_back(cfg_row(moi_pkg::RegLinear, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(moi_pkg::RegAngular, 32'hFFFF_FFFF));
    rows.push_back(sample_row(-32768, -32768, -32768, -32768, 1'b0));
    rows.push_back(sample_row(32767, 32767, 32767, 32767, 1'b0));
    rows.push_back(sample_row(-32768, -32768, -32768, -32768, 1'b0));
    rows.push_back(sample_row(32767, -32768, 32767, -32768, 1'b0));
    rows.push_back(sample_row(-32768, 32767, -32768, 32767, 1'b0));
    rows.push_back(sample_row(32767, -32768, -32768, 32767, 1'b0));
    rows.push_back(sample_row(1, 0, 0, 1, 1'b0));
    rows.push_back(sample_row(2, -1, 2, -1, 1'b0));
    rows.push_back(sample_row(2, -1, 2, -1, 1'b0));
    rows.push_back(cfg_row(moi_pkg::RegLinear, 32'd1));
    rows.push_back(cfg_row(moi_pkg::RegAngular, 32'h0100_0000));
    rows.push_back(sample_row(1000, -1000, 1000, -1000, 1'b0));
    rows.push_back(sample_row(2000, -2000, 2000, -2000, 1'b0));
    rows.push_back(sample_row(3000, 1000, 3000, 1000, 1'b0));
    rows.push_back(sample_row(-5, -5, -5, -5, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        in_bus.valid <= 1'b0;
        wait_drained();
        write_reg(rows[i].reg_idx, rows[i].value);
      end else begin
        send_sample(rows[i].cnt, seq, rows[i].has_pose, rows[i].pose);
        seq++;
      end
    end

    lin_set = '{$urandom(), 32'hFFFF_FFFF, 32'd1, $urandom_range(0, 1 << 20), 32'd0,
                $urandom()};
    ang_set = '{$urandom(), 32'hFFFF_FFFF, 32'd1, $urandom_range(0, 1 << 20),
                $urandom(), 32'd0};
    for (int ph = 0; ph < 6; ph++) begin
      in_bus.valid <= 1'b0;
      wait_drained();
      write_reg(moi_pkg::RegLinear, lin_set[ph]);
      write_reg(moi_pkg::RegAngular, ang_set[ph]);
      for (int n = 0; n < 140; n++) begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 3) == 0)
            cnt[k] = 16'($urandom());
          else
            cnt[k] = sent_cnt[k] + $signed(16'($urandom_range(0, 600)) - 16'd300);
        end
        send_sample(cnt, seq, 1'b0, none);
        seq++;
      end
    end
    in_bus.valid <= 1'b0;
    wait_drained();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
